// ===== rtl/numeric_literal_accumulator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the numeric literal accumulator
// Wrap concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_ACCUMULATOR_CORE_ASSERT_SVH
`define NUMERIC_LITERAL_ACCUMULATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check that cons holds in the cycle in which ante holds.
`define NLA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Check that cons holds in the cycle after ante holds.
`define NLA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define NLA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define NLA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/nla_pkg.sv =====
// ----------------------------------------------------------------------------
// Numeric literal accumulator package
// Shared types, codes and the character-to-digit decoder.
// ----------------------------------------------------------------------------
package nla_pkg;

   // Value kinds
   localparam logic [2:0] KIND_UINT      = 3'd0;
   localparam logic [2:0] KIND_SINT      = 3'd1;
   localparam logic [2:0] KIND_FLOAT     = 3'd2;
   localparam logic [2:0] KIND_FIXED     = 3'd3;
   localparam logic [2:0] KIND_DECIMAL   = 3'd4;

   // Register indexes
   localparam logic [1:0] CSR_VALUE_KIND  = 2'd0;
   localparam logic [1:0] CSR_NUM_BASE    = 2'd1;
   localparam logic [1:0] CSR_VALUE_WIDTH = 2'd2;

   // Register reset values
   localparam logic [2:0] KIND_RESET  = KIND_UINT;
   localparam logic [5:0] BASE_RESET  = 6'd10;
   localparam logic [6:0] WIDTH_RESET = 7'd64;

   // Radix limits
   localparam logic [5:0] RADIX_DEC     = 6'd10;
   localparam logic [5:0] RADIX_MIN     = 6'd2;
   localparam logic [5:0] RADIX_MAX     = 6'd36;
   localparam logic [5:0] RADIX_EXP_MAX = 6'd14;
   localparam logic [6:0] WIDTH_MAX     = 7'd64;

   // Characters
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UE    = 8'h45;
   localparam logic [7:0] CHAR_UZ    = 8'h5A;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LE    = 8'h65;
   localparam logic [7:0] CHAR_LZ    = 8'h7A;

   localparam logic [5:0] DIGIT_NONE   = 6'd63;
   localparam logic [5:0] LETTER_VALUE = 6'd10;

   // Exponent phase codes
   localparam logic [1:0] EXP_IDLE = 2'd0;
   localparam logic [1:0] EXP_MARK = 2'd1;
   localparam logic [1:0] EXP_TAIL = 2'd2;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_RANGE = 2'd1,
      ERR_DIGIT = 2'd2
   } error_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [5:0] base;
      logic [6:0] width;
   } cfg_type;

   typedef struct packed {
      logic [63:0] acc;
      logic        overflowed;
      logic        dot_seen;
      logic        exp_seen;
      logic [1:0]  exp_phase;
      logic        negative;
      error_type   first_error;
   } token_state_type;

   localparam token_state_type TOKEN_CLEAR = '{
      acc: 64'd0, overflowed: 1'b0, dot_seen: 1'b0, exp_seen: 1'b0,
      exp_phase: EXP_IDLE, negative: 1'b0, first_error: ERR_NONE
   };

   function automatic logic is_int_kind(input logic [2:0] kind);
      return (kind == KIND_UINT) || (kind == KIND_SINT);
   endfunction

   // Map a character to its digit value; DIGIT_NONE is above every radix.
   function automatic logic [5:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d = c - CHAR_0;
         return d[5:0];
      end
      if (c >= CHAR_LA && c <= CHAR_LZ) begin
         d = c - CHAR_LA;
         return d[5:0] + LETTER_VALUE;
      end
      if (c >= CHAR_UA && c <= CHAR_UZ) begin
         d = c - CHAR_UA;
         return d[5:0] + LETTER_VALUE;
      end
      return DIGIT_NONE;
   endfunction

endpackage

// ===== rtl/nla_step.sv =====
// ----------------------------------------------------------------------------
// Character step
// Next token state for one character: sign, point, exponent, digit fold.
// ----------------------------------------------------------------------------
module nla_step (
   input  nla_pkg::cfg_type         cfg,
   input  logic [7:0]               char_code,
   input  logic                     is_string_token,
   input  logic                     is_first,
   input  nla_pkg::token_state_type tok_cur,
   output nla_pkg::token_state_type tok_next
);
   import nla_pkg::*;

   logic [5:0]      radix;
   logic [5:0]      digit;
   logic [69:0]     fold;
   logic            fold_ovf;
   logic            is_exp_char;
   token_state_type base_tok;
   logic            skip;

   // Kinds 3 and 4 always use ten; otherwise a base below 2 uses ten and one above 36 clamps to 36.
   always_comb begin
      if (cfg.kind == KIND_FIXED || cfg.kind == KIND_DECIMAL) begin
         radix = RADIX_DEC;
      end else if (cfg.base < RADIX_MIN) begin
         radix = RADIX_DEC;
      end else if (cfg.base > RADIX_MAX) begin
         radix = RADIX_MAX;
      end else begin
         radix = cfg.base;
      end
   end

   assign digit       = digit_of(char_code);
   assign fold        = 70'(base_tok.acc) * 70'(radix) + 70'(digit);
   assign fold_ovf    = |fold[69:64];
   assign is_exp_char = (char_code == CHAR_LE || char_code == CHAR_UE) &&
                        (radix <= RADIX_EXP_MAX);

   always_comb begin
      base_tok = tok_cur;
      skip     = 1'b0;
      if (is_first) begin
         base_tok = TOKEN_CLEAR;
         if (char_code == CHAR_MINUS) begin
            base_tok.negative = 1'b1;
            skip              = 1'b1;
            if (cfg.kind == KIND_UINT) begin
               base_tok.first_error = ERR_RANGE;
            end
         end
      end
   end

   always_comb begin
      tok_next = base_tok;
      if (!skip && base_tok.first_error == ERR_NONE) begin
         if (is_string_token) begin
            if (is_int_kind(cfg.kind)) begin
               if (digit >= radix) begin
                  tok_next.first_error = ERR_DIGIT;
               end else if (!base_tok.overflowed && !base_tok.dot_seen) begin
                  if (fold_ovf) tok_next.overflowed = 1'b1;
                  else          tok_next.acc        = fold[63:0];
               end
            end
         end else if (char_code == CHAR_DOT) begin
            tok_next.dot_seen = 1'b1;
         end else if (is_exp_char) begin
            tok_next.exp_seen  = 1'b1;
            tok_next.exp_phase = EXP_MARK;
         end else if (base_tok.exp_phase != EXP_IDLE) begin
            tok_next.exp_phase = EXP_TAIL;
         end else if (digit >= radix) begin
            tok_next.first_error = ERR_DIGIT;
         end else if (!base_tok.overflowed && !base_tok.dot_seen) begin
            if (fold_ovf) tok_next.overflowed = 1'b1;
            else          tok_next.acc        = fold[63:0];
         end
      end
   end

endmodule

// ===== rtl/nla_range.sv =====
// ----------------------------------------------------------------------------
// Range check
// Final error code of a token against the declared width and signedness.
// ----------------------------------------------------------------------------
module nla_range (
   input  nla_pkg::cfg_type         cfg,
   input  nla_pkg::token_state_type tok,
   output nla_pkg::error_type       error_code
);
   import nla_pkg::*;

   logic [6:0]  w;
   logic [5:0]  shift_u;
   logic [5:0]  shift_s;
   logic [63:0] top_s;
   logic [63:0] limit;

   assign w       = (cfg.width == 7'd0 || cfg.width > WIDTH_MAX) ? WIDTH_MAX : cfg.width;
   assign shift_u = w[5:0];
   assign shift_s = 6'(w - 7'd1);
   assign top_s   = 64'd1 << shift_s;

   always_comb begin
      if (cfg.kind == KIND_UINT) begin
         limit = (w == WIDTH_MAX) ? '1 : ((64'd1 << shift_u) - 64'd1);
      end else if (tok.negative) begin
         limit = top_s;
      end else begin
         limit = top_s - 64'd1;
      end
   end

   always_comb begin
      if (tok.first_error != ERR_NONE) begin
         error_code = tok.first_error;
      end else if (!is_int_kind(cfg.kind)) begin
         error_code = ERR_NONE;
      end else if (tok.overflowed || tok.acc > limit) begin
         error_code = ERR_RANGE;
      end else begin
         error_code = ERR_NONE;
      end
   end

endmodule

// ===== rtl/numeric_literal_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// Numeric literal accumulator core
// Folds one token character per request into a 64-bit radix accumulator
// and reports magnitude, sign, point/exponent flags and error on the last.
// ----------------------------------------------------------------------------
//  channel | ports                     | direction | moves
//  req     | req_valid / req_ready     | in        | one character request
//  rsp     | rsp_valid / rsp_ready     | out       | one token result
//  csr     | csr_wr_en, index, wdata   | in        | register write
//
//  A request is processed while it sits in the input register; a last
//  character's result then loads into the output register and rsp_valid
//  rises; one request per cycle unless a last character waits on a busy output.
//  Multiply-add, overflow test and range compare are combinational between the two registers.
//  Reset clears the configuration registers, token state and both valid flags at once.
//  A stalled result holds only a waiting last character and the requests behind it.
// ----------------------------------------------------------------------------
`include "numeric_literal_accumulator_core_assert.svh"

module numeric_literal_accumulator_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_is_string_token,
   input  logic        req_is_first,
   input  logic        req_is_last,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_magnitude,
   output logic        rsp_is_negative,
   output logic        rsp_saw_dot,
   output logic        rsp_saw_exponent,
   output logic [1:0]  rsp_error_code,
   // configuration
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   import nla_pkg::*;

   // Configuration registers
   cfg_type         cfg_ff, cfg_in;

   // Input register
   logic            pipe_valid_ff, pipe_valid_in;
   logic [7:0]      pipe_char_ff;
   logic            pipe_str_ff;
   logic            pipe_first_ff;
   logic            pipe_last_ff;

   // Token state
   token_state_type tok_ff, tok_in;
   token_state_type tok_step;

   // Output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [63:0]     rsp_mag_ff;
   logic            rsp_neg_ff;
   logic            rsp_dot_ff;
   logic            rsp_exp_ff;
   error_type       rsp_err_ff;
   error_type       range_err;

   logic            out_free;
   logic            proc;
   logic            take;

   // Process the held character unless it would need a busy output slot.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign proc      = pipe_valid_ff && (!pipe_last_ff || out_free);
   assign req_ready = !pipe_valid_ff || proc;
   assign take      = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VALUE_KIND:  cfg_in.kind  = csr_wdata[2:0];
            CSR_NUM_BASE:    cfg_in.base  = csr_wdata[5:0];
            CSR_VALUE_WIDTH: cfg_in.width = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   nla_step u_step (
      .cfg             (cfg_ff),
      .char_code       (pipe_char_ff),
      .is_string_token (pipe_str_ff),
      .is_first        (pipe_first_ff),
      .tok_cur         (tok_ff),
      .tok_next        (tok_step)
   );

   nla_range u_range (
      .cfg        (cfg_ff),
      .tok        (tok_step),
      .error_code (range_err)
   );

   assign tok_in        = proc ? tok_step : tok_ff;
   assign pipe_valid_in = take || (pipe_valid_ff && !proc);

   // Drop the result once taken; load a new one on a processed last char.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (proc && pipe_last_ff) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '{kind: KIND_RESET, base: BASE_RESET, width: WIDTH_RESET};
         pipe_valid_ff <= 1'b0;
         tok_ff        <= TOKEN_CLEAR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         pipe_valid_ff <= pipe_valid_in;
         tok_ff        <= tok_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers: hold unless loaded.
   always_ff @(posedge clock) begin
      if (take) begin
         pipe_char_ff  <= req_char_code;
         pipe_str_ff   <= req_is_string_token;
         pipe_first_ff <= req_is_first;
         pipe_last_ff  <= req_is_last;
      end
      if (proc && pipe_last_ff) begin
         rsp_mag_ff <= tok_step.acc;
         rsp_neg_ff <= tok_step.negative;
         rsp_dot_ff <= tok_step.dot_seen;
         rsp_exp_ff <= tok_step.exp_seen;
         rsp_err_ff <= range_err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_magnitude    = rsp_mag_ff;
   assign rsp_is_negative  = rsp_neg_ff;
   assign rsp_saw_dot      = rsp_dot_ff;
   assign rsp_saw_exponent = rsp_exp_ff;
   assign rsp_error_code   = rsp_err_ff;

   // Overflow stays set until the next token begins.
   `NLA_ASSERT_NEXT(a_ovf_sticky, clock, reset,
      tok_ff.overflowed && !(proc && pipe_first_ff), tok_ff.overflowed,
      "overflow flag dropped inside a token")
   // After an error the accumulator and error code freeze for the token.
   `NLA_ASSERT_NEXT(a_err_freeze, clock, reset,
      (tok_ff.first_error != ERR_NONE) && !(proc && pipe_first_ff),
      $stable(tok_ff.acc) && $stable(tok_ff.first_error),
      "token state moved after an error")
   // Digits after a decimal point are not accumulated.
   `NLA_ASSERT_NEXT(a_dot_freeze, clock, reset,
      tok_ff.dot_seen && !(proc && pipe_first_ff),
      $stable(tok_ff.acc) && tok_ff.dot_seen,
      "accumulator moved after a point")
   // An exponent phase only exists once an exponent marker was seen.
   `NLA_ASSERT_SAME(a_exp_phase, clock, reset,
      tok_ff.exp_phase != EXP_IDLE, tok_ff.exp_seen,
      "exponent phase without marker")

endmodule
